// ===== src/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants, types and pointer helpers for the sliding window maximum
// block.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int WINDOW_MAX = 1024;
   localparam int SAMPLE_W   = 32;
   localparam int POS_W      = 32;
   localparam int CFG_W      = 11;
   localparam int PTR_W      = $clog2(WINDOW_MAX);
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic        [POS_W-1:0]    position;
   } swm_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD_RD,
      ST_HEAD_CHK,
      ST_BACK_RD,
      ST_BACK_CHK,
      ST_PUSH,
      ST_OUT_RD,
      ST_OUT_LOAD
   } swm_state_type;

   typedef struct packed {
      logic load;
      logic rd_head;
      logic rd_back;
      logic drop_head;
      logic drop_tail;
      logic push;
      logic out_load;
   } swm_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic stale;
      logic back_ge;
      logic filled_next;
      logic out_busy;
   } swm_status_type;

   // ring pointer step, valid for any depth
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] result;
      if (ptr == PTR_W'(WINDOW_MAX - 1)) begin
         result = '0;
      end else begin
         result = ptr + PTR_W'(1);
      end
      return result;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] result;
      if (ptr == '0) begin
         result = PTR_W'(WINDOW_MAX - 1);
      end else begin
         result = ptr - PTR_W'(1);
      end
      return result;
   endfunction

endpackage

// ===== src/swm_if.sv =====
// ----------------------------------------------------------------------------
// swm_req_if / swm_rsp_if
// Valid/ready channels carrying sample beats in and maximum beats out.
// ----------------------------------------------------------------------------
interface swm_req_if;
   import swm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       start_req;

   modport source (output valid, output sample, output start_req, input ready);
   modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface swm_rsp_if;
   import swm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] window_max;
   logic        [POS_W-1:0]    max_position;

   modport source (output valid, output window_max, output max_position, input ready);
   modport sink   (input valid, input window_max, input max_position, output ready);
endinterface

// ===== src/swm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer for one sample: stale front check, back pops, push and result
// read-out.
// ----------------------------------------------------------------------------
module swm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  swm_pkg::swm_status_type status,
   output swm_pkg::swm_cmd_type    cmd
);
   import swm_pkg::*;

   swm_state_type state_ff;
   swm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_HEAD_RD;
            end
         end
         ST_HEAD_RD: begin
            if (status.count_zero) begin
               state_in = ST_BACK_RD;
            end else begin
               cmd.rd_head = 1'b1;
               state_in    = ST_HEAD_CHK;
            end
         end
         ST_HEAD_CHK: begin
            cmd.drop_head = status.stale;
            state_in      = ST_BACK_RD;
         end
         ST_BACK_RD: begin
            if (status.count_zero) begin
               state_in = ST_PUSH;
            end else begin
               cmd.rd_back = 1'b1;
               state_in    = ST_BACK_CHK;
            end
         end
         ST_BACK_CHK: begin
            if (status.back_ge) begin
               state_in = ST_PUSH;
            end else begin
               cmd.drop_tail = 1'b1;
               state_in      = ST_BACK_RD;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = status.filled_next ? ST_OUT_RD : ST_IDLE;
         end
         ST_OUT_RD: begin
            cmd.rd_head = 1'b1;
            state_in    = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            // hold until the previous result beat has left
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/swm_datapath.sv =====
// ----------------------------------------------------------------------------
// swm_datapath
// Deque memory, ring pointers, stream counter, window register and the
// output register.
// ----------------------------------------------------------------------------
module swm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  swm_pkg::swm_cmd_type                 cmd,
   output swm_pkg::swm_status_type              status,
   input  logic signed [swm_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                req_start_req,
   input  logic                                csr_write_enable,
   input  logic        [swm_pkg::CFG_W-1:0]     csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [swm_pkg::SAMPLE_W-1:0]  rsp_window_max,
   output logic        [swm_pkg::POS_W-1:0]     rsp_max_position
);
   import swm_pkg::*;

   swm_entry_type deque_mem [WINDOW_MAX];

   logic [CFG_W-1:0]           window_ff;
   logic [PTR_W-1:0]           head_ff;
   logic [PTR_W-1:0]           head_in;
   logic [PTR_W-1:0]           tail_ff;
   logic [PTR_W-1:0]           tail_in;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic [POS_W-1:0]           counter_ff;
   logic [POS_W-1:0]           counter_in;
   logic                       filled_ff;
   logic                       filled_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   swm_entry_type              rd_data_ff;
   logic [PTR_W-1:0]           rd_addr;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic signed [SAMPLE_W-1:0] out_value_ff;
   logic [POS_W-1:0]           out_pos_ff;
   logic [CFG_W-1:0]           win_eff;
   logic [POS_W-1:0]           age;
   logic                       count_full;

   // zero acts as one, above the deque depth saturates
   always_comb begin
      if (window_ff == '0) begin
         win_eff = CFG_W'(1);
      end else if (32'(window_ff) > WINDOW_MAX) begin
         win_eff = CFG_W'(WINDOW_MAX);
      end else begin
         win_eff = window_ff;
      end
   end

   assign age        = counter_ff - rd_data_ff.position;
   assign count_full = (32'(count_ff) >= WINDOW_MAX);

   assign status.count_zero  = (count_ff == '0);
   assign status.stale       = (age >= POS_W'(win_eff));
   assign status.back_ge     = (rd_data_ff.value >= sample_ff);
   assign status.filled_next = filled_ff || (counter_ff >= POS_W'(win_eff) - POS_W'(1));
   assign status.out_busy    = out_valid_ff;

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      counter_in = counter_ff;
      filled_in  = filled_ff;
      priority if (cmd.load && req_start_req) begin
         head_in    = '0;
         tail_in    = '0;
         count_in   = '0;
         counter_in = '0;
         filled_in  = 1'b0;
      end else if (cmd.drop_head) begin
         head_in  = ptr_inc(head_ff);
         count_in = count_ff - CNT_W'(1);
      end else if (cmd.drop_tail) begin
         tail_in  = ptr_dec(tail_ff);
         count_in = count_ff - CNT_W'(1);
      end else if (cmd.push) begin
         // a full deque gives up its front entry to make room
         if (count_full) begin
            head_in = ptr_inc(head_ff);
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
         tail_in    = ptr_inc(tail_ff);
         counter_in = counter_ff + POS_W'(1);
         filled_in  = status.filled_next;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         counter_ff <= '0;
         filled_ff  <= 1'b0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         counter_ff <= counter_in;
         filled_ff  <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= CFG_W'(1);
      end else if (csr_write_enable) begin
         window_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_sample;
      end
   end

   assign rd_addr = cmd.rd_head ? head_ff : ptr_dec(tail_ff);

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         deque_mem[tail_ff] <= '{value: sample_ff, position: counter_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_head || cmd.rd_back) begin
         rd_data_ff <= deque_mem[rd_addr];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_value_ff <= rd_data_ff.value;
         out_pos_ff   <= rd_data_ff.position;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_window_max   = out_value_ff;
   assign rsp_max_position = out_pos_ff;

endmodule

// ===== src/sliding_window_maximum_core.sv =====
// sequence: an accepted sample goes through a front read and stale check (skipped on an empty
//    deque), a back read and compare per popped entry, the push and, with the window full, a
//    front read and result load that waits out a stalled beat; one sample at a time, set by the
//    single read port of the deque memory and the compare after each read
// reset: synchronous, clears pointers, count, stream counter and window size to 1;
//    the deque memory is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// sliding_window_maximum_core
// Streaming window maximum over signed samples using a monotonic deque.
// ----------------------------------------------------------------------------
module sliding_window_maximum_core (
   input  logic                         clock,
   input  logic                         reset,
   swm_req_if.sink                      req_bus,
   swm_rsp_if.source                    rsp_bus,
   input  logic                         csr_write_enable,
   input  logic [swm_pkg::CFG_W-1:0]    csr_write_data
);
   import swm_pkg::*;

   swm_cmd_type    cmd;
   swm_status_type status;

   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   swm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_bus.sample),
      .req_start_req    (req_bus.start_req),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_window_max   (rsp_bus.window_max),
      .rsp_max_position (rsp_bus.max_position)
   );

endmodule

// ===== src/swm_checker.sv =====
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks on the sliding window maximum core, bound to the top.
// ----------------------------------------------------------------------------
module swm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [swm_pkg::SAMPLE_W-1:0] rsp_window_max,
   input logic        [swm_pkg::POS_W-1:0]    rsp_max_position
);
   import swm_pkg::*;

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   // a stalled result beat keeps its valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result valid dropped while stalled");

   // and its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_window_max) && $stable(rsp_max_position))
      else $error("result payload changed while stalled");

   // one sample at a time: no second beat right after an accepted one
   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("sample accepted in back-to-back cycles");

   // a result beat does not rise straight after a sample beat is taken
   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !$rose(rsp_valid))
      else $error("result beat appeared one cycle after a sample beat");

endmodule

bind sliding_window_maximum_core swm_checker u_swm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_window_max   (rsp_bus.window_max),
   .rsp_max_position (rsp_bus.max_position)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks sliding_window_maximum_core against a monotonic deque predictor.
// A short table of directed samples covers reset, the value extremes, window
// zero, saturation, restarts and a window shrunk mid-stream. Random phases
// follow, each with its own window setting, sample pattern and idling on
// both channels. Every result beat is compared with the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import swm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DIR_ROWS    = 25;
   localparam int RANDOM_ITEMS = 300;
   localparam int BIG_PHASE_ITEMS = 64;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI = 32'sh7fffffff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = 32'sh80000000;

   typedef enum int {
      PAT_RANDOM,
      PAT_CLUSTER,
      PAT_FALLING,
      PAT_EXTREME
   } sample_pattern_type;

   typedef struct {
      logic                       set_cfg;
      logic [CFG_W-1:0]           cfg;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       first;
      logic                       typed;
      logic signed [SAMPLE_W-1:0] max_value;
      logic [POS_W-1:0]           max_pos;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CFG_W-1:0] csr_write_data;

   swm_req_if req_bus ();
   swm_rsp_if rsp_bus ();

   sliding_window_maximum_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // predictor state
   logic signed [SAMPLE_W-1:0] dq_value [WINDOW_MAX];
   logic [POS_W-1:0]           dq_pos [WINDOW_MAX];
   int                         dq_head;
   int                         dq_tail;
   int                         dq_live;
   logic [POS_W-1:0]           stream_pos;
   logic                       window_full;
   logic [CFG_W-1:0]           window_cfg;
   int                         last_pops;

   swm_entry_type expected_max [$];

   directed_row_type directed_rows [DIR_ROWS];

   int  errors;
   int  cycle_count;
   int  samples_sent;
   int  random_sent;
   int  beats_checked;
   int  settings_used;
   int  stall_left;
   logic send_idle_on;
   logic recv_idle_on;
   logic signed [SAMPLE_W-1:0] prev_sample;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sliding_window_maximum_core: mismatch");
         $finish;
      end
   end

   // advance the window by one sample, return 1 when a maximum beat is due
   function automatic logic slide_window(input logic signed [SAMPLE_W-1:0] s,
                                         input logic first,
                                         output swm_entry_type beat);
      int span;
      int back;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] age;
      span = int'(window_cfg);
      if (span == 0) begin
         span = 1;
      end
      if (span > WINDOW_MAX) begin
         span = WINDOW_MAX;
      end
      if (first) begin
         dq_head     = 0;
         dq_tail     = 0;
         dq_live     = 0;
         stream_pos  = '0;
         window_full = 1'b0;
      end
      pos = stream_pos;
      // at most one stale front entry leaves per sample
      if (dq_live != 0) begin
         age = pos - dq_pos[dq_head];
         if (age >= POS_W'(span)) begin
            dq_head = (dq_head + 1) % WINDOW_MAX;
            dq_live--;
         end
      end
      last_pops = 0;
      while (dq_live != 0) begin
         back = (dq_tail + WINDOW_MAX - 1) % WINDOW_MAX;
         if (dq_value[back] >= s) begin
            break;
         end
         dq_tail = back;
         dq_live--;
         last_pops++;
      end
      if (dq_live >= WINDOW_MAX) begin
         dq_head = (dq_head + 1) % WINDOW_MAX;
         dq_live--;
      end
      dq_value[dq_tail] = s;
      dq_pos[dq_tail]   = pos;
      dq_tail = (dq_tail + 1) % WINDOW_MAX;
      dq_live++;
      if (pos >= POS_W'(span - 1)) begin
         window_full = 1'b1;
      end
      stream_pos = pos + POS_W'(1);
      beat.value    = dq_value[dq_head];
      beat.position = dq_pos[dq_head];
      return window_full;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] next_sample(input sample_pattern_type pat);
      logic signed [SAMPLE_W-1:0] s;
      case (pat)
         PAT_CLUSTER: begin
            s = SAMPLE_W'($urandom_range(0, 7)) - SAMPLE_W'(3);
         end
         PAT_FALLING: begin
            if ($urandom_range(0, 7) == 0) begin
               s = $urandom;
            end else begin
               s = prev_sample - SAMPLE_W'($urandom_range(0, 3));
            end
         end
         PAT_EXTREME: begin
            case ($urandom_range(0, 4))
               0: s = SAMPLE_HI;
               1: s = SAMPLE_LO;
               2: s = '0;
               3: s = -1;
               default: s = $urandom;
            endcase
         end
         default: begin
            s = $urandom;
         end
      endcase
      return s;
   endfunction

   // drive one sample beat and wait for it to be taken
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic first,
                              input logic typed, input swm_entry_type typed_beat);
      swm_entry_type beat;
      logic due;
      int gap;
      req_bus.valid     <= 1'b1;
      req_bus.sample    <= s;
      req_bus.start_req <= first;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      due = slide_window(s, first, beat);
      if (typed) begin
         expected_max.insert(expected_max.size(), typed_beat);
      end else if (due) begin
         expected_max.insert(expected_max.size(), beat);
      end
      prev_sample = s;
      samples_sent++;
      gap = send_idle_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // window writes only once the block has drained
   task automatic write_window(input logic [CFG_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (expected_max.size() != 0) @(posedge clock);
      repeat (32 + 2 * last_pops) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      window_cfg = value;
      settings_used++;
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] window, input logic restart,
                            input int count, input sample_pattern_type pat);
      swm_entry_type none;
      logic first;
      none = '0;
      write_window(window);
      send_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < count; i++) begin
         if (i == 0) begin
            first = restart;
         end else begin
            // occasional stray restart inside a stream
            first = ($urandom_range(0, 39) == 0);
         end
         send_sample(next_sample(pat), first, 1'b0, none);
         random_sent++;
      end
   endtask

   // result side: random stalls, compare each beat with the oldest expectation
   always @(posedge clock) begin
      swm_entry_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_max.size() == 0) begin
               errors++;
               $display("%0t: maximum beat with none expected, got %0d @%0d",
                        $time, rsp_bus.window_max, rsp_bus.max_position);
            end else begin
               want = expected_max[0];
               expected_max.delete(0);
               beats_checked++;
               if (rsp_bus.window_max !== want.value) begin
                  errors++;
                  $display("%0t: window_max expected %0d, actual %0d",
                           $time, want.value, rsp_bus.window_max);
               end
               if (rsp_bus.max_position !== want.position) begin
                  errors++;
                  $display("%0t: max_position expected %0d, actual %0d",
                           $time, want.position, rsp_bus.max_position);
               end
            end
            stall_left = recv_idle_on ? $urandom_range(0, 7) : 0;
         end
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      swm_entry_type typed_beat;
      int sel;
      logic [CFG_W-1:0] window;
      errors        = 0;
      cycle_count   = 0;
      samples_sent  = 0;
      random_sent   = 0;
      beats_checked = 0;
      settings_used = 0;
      last_pops     = 0;
      prev_sample   = '0;
      send_idle_on  = 1'b1;
      recv_idle_on  = 1'b1;
      dq_head       = 0;
      dq_tail       = 0;
      dq_live       = 0;
      stream_pos    = '0;
      window_full   = 1'b0;
      window_cfg    = CFG_W'(1);

      //                set  cfg   sample      first typed max        pos
      directed_rows = '{
         '{1'b0, 11'd0,    SAMPLE_HI, 1'b1, 1'b1, SAMPLE_HI, 32'd0},
         '{1'b0, 11'd0,    SAMPLE_LO, 1'b0, 1'b1, SAMPLE_LO, 32'd1},
         '{1'b0, 11'd0,    -32'sd1,   1'b0, 1'b1, -32'sd1,   32'd2},
         '{1'b0, 11'd0,    32'sd0,    1'b0, 1'b1, 32'sd0,    32'd3},
         // window zero acts as one
         '{1'b1, 11'd0,    32'sd5,    1'b1, 1'b1, 32'sd5,    32'd0},
         '{1'b0, 11'd0,    32'sd3,    1'b0, 1'b1, 32'sd3,    32'd1},
         '{1'b1, 11'd3,    32'sd10,   1'b1, 1'b0, 32'sd0,    32'd0},
         '{1'b0, 11'd0,    32'sd20,   1'b0, 1'b0, 32'sd0,    32'd0},
         // equal values keep the earliest position
         '{1'b0, 11'd0,    32'sd20,   1'b0, 1'b1, 32'sd20,   32'd1},
         '{1'b0, 11'd0,    32'sd5,    1'b0, 1'b1, 32'sd20,   32'd1},
         '{1'b0, 11'd0,    32'sd1,    1'b0, 1'b1, 32'sd20,   32'd2},
         '{1'b0, 11'd0,    SAMPLE_LO, 1'b0, 1'b0, 32'sd0,    32'd0},
         '{1'b0, 11'd0,    SAMPLE_LO, 1'b0, 1'b0, 32'sd0,    32'd0},
         '{1'b0, 11'd0,    SAMPLE_HI, 1'b0, 1'b1, SAMPLE_HI, 32'd7},
         // restart in the middle of a stream
         '{1'b0, 11'd0,    32'sd9,    1'b1, 1'b0, 32'sd0,    32'd0},
         '{1'b0, 11'd0,    32'sd8,    1'b0, 1'b0, 32'sd0,    32'd0},
         '{1'b0, 11'd0,    32'sd7,    1'b0, 1'b0, 32'sd0,    32'd0},
         '{1'b1, 11'd5,    32'sd6,    1'b0, 1'b0, 32'sd0,    32'd0},
         '{1'b0, 11'd0,    32'sd5,    1'b0, 1'b0, 32'sd0,    32'd0},
         '{1'b0, 11'd0,    32'sd4,    1'b0, 1'b0, 32'sd0,    32'd0},
         // shrink leaves stale entries behind, one leaves per beat
         '{1'b1, 11'd1,    32'sd3,    1'b0, 1'b0, 32'sd0,    32'd0},
         '{1'b0, 11'd0,    32'sd2,    1'b0, 1'b0, 32'sd0,    32'd0},
         '{1'b0, 11'd0,    32'sd1,    1'b0, 1'b0, 32'sd0,    32'd0},
         '{1'b1, 11'd2047, 32'sd0,    1'b1, 1'b0, 32'sd0,    32'd0},
         '{1'b0, 11'd0,    SAMPLE_HI, 1'b0, 1'b0, 32'sd0,    32'd0}
      };

      reset             <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_write_data    <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.sample    <= '0;
      req_bus.start_req <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIR_ROWS; r++) begin
         if (directed_rows[r].set_cfg) begin
            write_window(directed_rows[r].cfg);
         end
         typed_beat.value    = directed_rows[r].max_value;
         typed_beat.position = directed_rows[r].max_pos;
         send_sample(directed_rows[r].sample, directed_rows[r].first,
                     directed_rows[r].typed, typed_beat);
      end

      while (random_sent < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 9);
         case (sel)
            0:       window = '0;
            1:       window = CFG_W'(1);
            2, 3:    window = CFG_W'($urandom_range(13, 48));
            default: window = CFG_W'($urandom_range(2, 12));
         endcase
         run_phase(window, $urandom_range(0, 3) != 0, $urandom_range(8, 40),
                   sample_pattern_type'($urandom_range(0, 3)));
      end
      // one stream at the register ceiling, saturated to the deque depth
      run_phase('1, 1'b1, BIG_PHASE_ITEMS, sample_pattern_type'($urandom_range(0, 1)));
      // and a short one at the smallest window to finish
      run_phase(CFG_W'(1), 1'b0, 16, PAT_EXTREME);

      req_bus.valid <= 1'b0;
      while (expected_max.size() != 0) @(posedge clock);
      repeat (32 + 2 * last_pops) @(posedge clock);

      $display("covered %0d samples over %0d window settings, %0d maximum beats compared",
               samples_sent, settings_used, beats_checked);
      $display("windows ranged from zero to the 11-bit ceiling, with restarts and idling");
      if (errors == 0) begin
         $display("sliding_window_maximum_core: match");
      end else begin
         $display("sliding_window_maximum_core: mismatch");
      end
      $finish;
   end

endmodule
